// ===== rtl/infix_to_prefix_operator_stack_defines.svh =====
// Assertion macros shared by the checker of the operator stack block.
`ifndef INFIX_TO_PREFIX_OPERATOR_STACK_DEFINES_SVH
`define INFIX_TO_PREFIX_OPERATOR_STACK_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define ITP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/itp_pkg.sv =====
// Package with the types, character codes and decode functions of the operator stack.
`default_nettype none
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SYM_W       = 8;
  localparam int ERR_W       = 2;

  localparam logic [SYM_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [SYM_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYM_W-1:0] CH_PCT   = 8'h25;
  localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

  typedef enum logic [2:0] {
    OP_RPAR = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_POW  = 3'd6
  } op_code_t;

  typedef enum logic [2:0] {
    K_OTHER,
    K_RPAR,
    K_ADDSUB,
    K_MULDIV,
    K_POW,
    K_LPAR
  } sym_kind_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

  // Command that the controller sends down the row of stack cells.
  typedef struct packed {
    stk_op_t  op;
    op_code_t code;
  } stk_ctl_t;

  function automatic sym_kind_t classify(input logic [SYM_W-1:0] s);
    sym_kind_t k;
    case (s) inside
      CH_RPAR:                  k = K_RPAR;
      CH_LPAR:                  k = K_LPAR;
      CH_PLUS, CH_MINUS:        k = K_ADDSUB;
      CH_STAR, CH_SLASH, CH_PCT: k = K_MULDIV;
      CH_CARET:                 k = K_POW;
      default:                  k = K_OTHER;
    endcase
    return k;
  endfunction

  function automatic op_code_t sym_to_code(input logic [SYM_W-1:0] s);
    op_code_t c;
    case (s)
      CH_RPAR:  c = OP_RPAR;
      CH_PLUS:  c = OP_ADD;
      CH_MINUS: c = OP_SUB;
      CH_STAR:  c = OP_MUL;
      CH_SLASH: c = OP_DIV;
      CH_PCT:   c = OP_MOD;
      default:  c = OP_POW;
    endcase
    return c;
  endfunction

  function automatic logic [SYM_W-1:0] code_to_char(input op_code_t c);
    logic [SYM_W-1:0] ch;
    case (c)
      OP_RPAR: ch = CH_RPAR;
      OP_ADD:  ch = CH_PLUS;
      OP_SUB:  ch = CH_MINUS;
      OP_MUL:  ch = CH_STAR;
      OP_DIV:  ch = CH_SLASH;
      OP_MOD:  ch = CH_PCT;
      OP_POW:  ch = CH_CARET;
      default: ch = '0;
    endcase
    return ch;
  endfunction

  // True when the operator on top must be popped before this symbol is handled.
  function automatic logic pop_cond(input sym_kind_t k, input op_code_t t);
    logic p;
    case (k)
      K_ADDSUB: p = (t == OP_ADD) || (t == OP_SUB) || (t == OP_MUL) ||
                    (t == OP_DIV) || (t == OP_MOD);
      K_MULDIV: p = (t == OP_MUL) || (t == OP_DIV) || (t == OP_MOD) ||
                    (t == OP_POW);
      K_POW:    p = (t == OP_POW);
      K_LPAR:   p = (t != OP_RPAR);
      default:  p = 1'b0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/itp_in_if.sv =====
// Input channel: one character of the reversed infix text per transfer.
`default_nettype none
interface itp_in_if import itp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             final_symbol;

  modport source (output valid, output symbol, output final_symbol, input ready);
  modport sink   (input valid, input symbol, input final_symbol, output ready);
endinterface
`default_nettype wire

// ===== rtl/itp_out_if.sv =====
// Result channel: one emitted character or status word per transfer.
`default_nettype none
interface itp_out_if import itp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] out_symbol;
  logic             out_present;
  logic             run_last;
  logic             expression_end;
  logic [ERR_W-1:0] error_code;

  modport source (output valid, output out_symbol, output out_present, output run_last,
                  output expression_end, output error_code, input ready);
  modport sink   (input valid, input out_symbol, input out_present, input run_last,
                  input expression_end, input error_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/itp_cell.sv =====
// One stack cell: holds an operator code and shifts with its neighbors.
`default_nettype none
module itp_cell import itp_pkg::*; (
  input  wire logic     clk,
  input  stk_op_t       op,
  input  op_code_t      from_above,
  input  op_code_t      from_below,
  output op_code_t      value
);

  op_code_t val_r;

  always_ff @(posedge clk) begin
    case (op)
      STK_PUSH: val_r <= from_above;
      STK_POP:  val_r <= from_below;
      default:  val_r <= val_r;
    endcase
  end

  assign value = val_r;

endmodule
`default_nettype wire

// ===== rtl/itp_stack.sv =====
// Row of stack cells; cell zero is the top of the operator stack.
`default_nettype none
module itp_stack import itp_pkg::*; (
  input  wire logic clk,
  input  stk_ctl_t  ctl,
  output op_code_t  top
);

  op_code_t vals [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    op_code_t above;
    op_code_t below;

    if (i == 0) begin : g_first
      assign above = ctl.code;
    end else begin : g_mid
      assign above = vals[i-1];
    end

    // The bottom cell takes a filler on a pop; it lies beyond the count then.
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = OP_RPAR;
    end else begin : g_inner
      assign below = vals[i+1];
    end

    itp_cell u_cell (
      .clk        (clk),
      .op         (ctl.op),
      .from_above (above),
      .from_below (below),
      .value      (vals[i])
    );
  end

  assign top = vals[0];

endmodule
`default_nettype wire

// ===== rtl/infix_to_prefix_operator_stack.sv =====
// Steps: an item passes through POP, then also through FLUSH for the final
//   character, and DONE releases the item's last result.
// Throughput: one item at a time; the next transfer is taken once the item's
//   last result sits in the output register. Output stalls hold the controller.
// Reset: rst_n is synchronous, active low; it empties the stack and clears
//   all handshake state. The stack cells themselves are not reset.
`default_nettype none
module infix_to_prefix_operator_stack import itp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  itp_in_if.sink    in_chan,
  itp_out_if.source out_chan
);

  // The controller walks one item through these steps. POP pops one operator a
  // cycle while the precedence rule holds and the output is free; in the cycle
  // it stops it does the item's own action (push, drop of the matching ')',
  // pass-through, or an error flag). FLUSH empties the stack after the final
  // character. DONE releases the last result with run_last and status fields.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POP   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SYM_W-1:0] sym_r;
  sym_kind_t        kind_r;
  logic             fin_r;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Each emitted character waits in a hold register until it is known whether
  // another result of the same item follows, so that run_last can be set.
  logic             hold_valid_r, hold_valid_nxt;
  logic [SYM_W-1:0] hold_sym_r, hold_sym_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_symbol_r, out_symbol_nxt;
  logic             out_present_r, out_present_nxt;
  logic             run_last_r, run_last_nxt;
  logic             expr_end_r, expr_end_nxt;
  logic [ERR_W-1:0] err_code_r, err_code_nxt;

  stk_ctl_t         stk_ctl;
  op_code_t         top_code;
  logic             out_free;
  logic             emit;
  logic [SYM_W-1:0] emit_sym;
  logic             in_xfer;
  logic             stack_empty;
  logic             stack_full;

  itp_stack u_stack (
    .clk (clk),
    .ctl (stk_ctl),
    .top (top_code)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign stack_empty   = (count_r == '0);
  assign stack_full    = (count_r == CNT_W'(STACK_DEPTH));

  always_comb begin
    state_nxt       = state_r;
    err_nxt         = err_r;
    count_nxt       = count_r;
    hold_valid_nxt  = hold_valid_r;
    hold_sym_nxt    = hold_sym_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_symbol_nxt  = out_symbol_r;
    out_present_nxt = out_present_r;
    run_last_nxt    = run_last_r;
    expr_end_nxt    = expr_end_r;
    err_code_nxt    = err_code_r;
    stk_ctl.op      = STK_HOLD;
    stk_ctl.code    = sym_to_code(sym_r);
    emit            = 1'b0;
    emit_sym        = code_to_char(top_code);

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          err_nxt   = ERR_NONE;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (out_free) begin
          if (!stack_empty && pop_cond(kind_r, top_code)) begin
            emit       = 1'b1;
            stk_ctl.op = STK_POP;
            count_nxt  = count_r - 1'b1;
          end else begin
            case (kind_r)
              K_OTHER: begin
                emit     = 1'b1;
                emit_sym = sym_r;
              end
              K_LPAR: begin
                if (!stack_empty) begin
                  // Top is the matching ')': drop it without a result.
                  stk_ctl.op = STK_POP;
                  count_nxt  = count_r - 1'b1;
                end else begin
                  err_nxt = ERR_UNMATCHED;
                end
              end
              default: begin
                if (stack_full) begin
                  err_nxt = ERR_OVERFLOW;
                end else begin
                  stk_ctl.op = STK_PUSH;
                  count_nxt  = count_r + 1'b1;
                end
              end
            endcase
            state_nxt = fin_r ? S_FLUSH : S_DONE;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (!stack_empty) begin
            emit       = 1'b1;
            stk_ctl.op = STK_POP;
            count_nxt  = count_r - 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (hold_valid_r || fin_r || (err_r != ERR_NONE)) begin
            out_valid_nxt   = 1'b1;
            out_symbol_nxt  = hold_valid_r ? hold_sym_r : '0;
            out_present_nxt = hold_valid_r;
            run_last_nxt    = 1'b1;
            expr_end_nxt    = fin_r;
            err_code_nxt    = err_r;
          end
          hold_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new character pushes the held one out as a result that is not the last.
    if (emit) begin
      if (hold_valid_r) begin
        out_valid_nxt   = 1'b1;
        out_symbol_nxt  = hold_sym_r;
        out_present_nxt = 1'b1;
        run_last_nxt    = 1'b0;
        expr_end_nxt    = 1'b0;
        err_code_nxt    = ERR_NONE;
      end
      hold_valid_nxt = 1'b1;
      hold_sym_nxt   = emit_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      err_r        <= ERR_NONE;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      err_r        <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sym_r  <= in_chan.symbol;
      kind_r <= classify(in_chan.symbol);
      fin_r  <= in_chan.final_symbol;
    end
    hold_sym_r    <= hold_sym_nxt;
    out_symbol_r  <= out_symbol_nxt;
    out_present_r <= out_present_nxt;
    run_last_r    <= run_last_nxt;
    expr_end_r    <= expr_end_nxt;
    err_code_r    <= err_code_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.out_symbol     = out_symbol_r;
  assign out_chan.out_present    = out_present_r;
  assign out_chan.run_last       = run_last_r;
  assign out_chan.expression_end = expr_end_r;
  assign out_chan.error_code     = err_code_r;

endmodule
`default_nettype wire

// ===== rtl/itp_checker.sv =====
// Port-level checker for the operator stack block and its bind statement.
`default_nettype none
`include "infix_to_prefix_operator_stack_defines.svh"
module itp_checker import itp_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic [SYM_W-1:0] out_symbol,
  input wire logic             out_present,
  input wire logic             run_last,
  input wire logic             expression_end,
  input wire logic [ERR_W-1:0] error_code
);

  `ITP_ASSERT_IMPL(a_status_zero, out_valid && !out_present, out_symbol == '0, "status result carries a character")
  `ITP_ASSERT_IMPL(a_status_last, out_valid && !out_present, run_last, "status result not marked last")
  `ITP_ASSERT_IMPL(a_end_last, out_valid && expression_end, run_last, "expression end off the last result")
  `ITP_ASSERT_IMPL(a_err_last, out_valid && (error_code != ERR_NONE), run_last && (error_code != 2'd3), "bad error report")
  `ITP_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "second transfer taken while busy")

endmodule

bind infix_to_prefix_operator_stack itp_checker u_itp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_symbol     (out_chan.out_symbol),
  .out_present    (out_chan.out_present),
  .run_last       (out_chan.run_last),
  .expression_end (out_chan.expression_end),
  .error_code     (out_chan.error_code)
);
`default_nettype wire
